[src/pmmcs_pkg.sv]
// Constants, codes, types and helpers for the min/max contrast stretch block.
package pmmcs_pkg;

  // Significant sample bits in the 16-bit modes (12 to 16).
  localparam int SAMPLE_BITS = 16;
  localparam int RAW_W       = 16;
  localparam int LEVEL_W     = 8;
  localparam int STEP_W      = $clog2(LEVEL_W);

  localparam logic [RAW_W-1:0] RANGE_LOW_INIT  = '1;
  localparam logic [RAW_W-1:0] RANGE_HIGH_INIT = '0;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = '1;

  typedef enum logic [2:0] {
    MODE_COLOR = 3'd0,
    MODE_U8    = 3'd1,
    MODE_S8    = 3'd2,
    MODE_U16   = 3'd3,
    MODE_S16   = 3'd4
  } pixel_mode_t;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_CONVERT = 2'd2
  } opcode_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_SCALE = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Offset a signed sample to unsigned: 0..255 in signed8 mode, 0..65535 otherwise.
  function automatic logic [RAW_W-1:0] offset_value(input logic [2:0] mode,
                                                     input logic [RAW_W-1:0] raw);
    logic signed [SAMPLE_BITS-1:0] sv;
    logic [RAW_W-1:0] ext;
    sv  = raw[SAMPLE_BITS-1:0];
    ext = RAW_W'(sv);
    if (mode == MODE_S8) begin
      offset_value = {8'h00, raw[7:0] ^ 8'h80};
    end else begin
      offset_value = ext ^ {1'b1, {(RAW_W-1){1'b0}}};
    end
  endfunction

  // floor(u * 255 / 65535) == floor(u / 257): high byte, less one if the low byte is smaller.
  function automatic logic [LEVEL_W-1:0] scale_u16(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] u;
    u = RAW_W'(raw[SAMPLE_BITS-1:0]);
    if (u[7:0] >= u[15:8]) begin
      scale_u16 = u[15:8];
    end else begin
      scale_u16 = u[15:8] - 8'd1;
    end
  endfunction

endpackage

[src/pixel_min_max_contrast_stretch.sv]
// Min/max contrast stretch: sample to 8-bit gray level, with a bit-serial divider.
//
// Each item carries an opcode and a 16-bit sample. Clear and measure are done
// in the idle state: clear resets the tracked range, and measure (in the two signed
// stretch modes only) folds the offset sample into the range. A convert always
// yields one gray level. In the pass and 16-bit scale modes a convert passes
// through transfer, then load of the output register. In the stretch modes,
// samples on or outside the measured range, or a flat range, saturate after
// the transfer and the range check; any other sample goes through
// floor((v-min)*255/(max-min)), in these steps: transfer, range
// subtract, times-255 shift-subtract, eight restoring-division steps (one
// quotient bit per cycle) and output load. The divider sets the worst-case
// rate. The output register decouples the sides: the next item is taken while
// a finished level still waits for its transfer. Write pixel_mode only while
// the block is idle.
module pixel_min_max_contrast_stretch (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_wr_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [pmmcs_pkg::RAW_W-1:0]     sample,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pmmcs_pkg::LEVEL_W-1:0]   gray_level
);

  pmmcs_pkg::state_t               state;
  logic [2:0]                      pixel_mode;
  logic [pmmcs_pkg::RAW_W-1:0]     range_low;
  logic [pmmcs_pkg::RAW_W-1:0]     range_high;

  // working registers of one convert
  logic [pmmcs_pkg::RAW_W-1:0]     vs;
  logic [pmmcs_pkg::RAW_W-1:0]     diff;
  logic [pmmcs_pkg::RAW_W-1:0]     den;
  logic [pmmcs_pkg::RAW_W-1:0]     rem;
  logic [pmmcs_pkg::LEVEL_W-1:0]   num_low;
  logic [pmmcs_pkg::LEVEL_W-1:0]   quot;
  logic [pmmcs_pkg::STEP_W-1:0]    step_cnt;

  logic                            in_xfer;
  logic                            out_xfer;
  logic                            stretching;
  logic [pmmcs_pkg::RAW_W-1:0]     in_offset;
  logic [pmmcs_pkg::LEVEL_W-1:0]   direct_level;
  logic [pmmcs_pkg::RAW_W+7:0]     scaled;
  logic [pmmcs_pkg::RAW_W+1:0]     trial;
  logic                            trial_ge;

  assign in_stall  = (state != pmmcs_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  assign stretching = (pixel_mode == pmmcs_pkg::MODE_S8) ||
                      (pixel_mode == pmmcs_pkg::MODE_S16);
  assign in_offset  = pmmcs_pkg::offset_value(pixel_mode, sample);

  // Pass modes (including the unused codes) take the low byte.
  always_comb begin
    if (pixel_mode == pmmcs_pkg::MODE_U16) begin
      direct_level = pmmcs_pkg::scale_u16(sample);
    end else begin
      direct_level = sample[pmmcs_pkg::LEVEL_W-1:0];
    end
  end

  // diff * 255 as (diff << 8) - diff
  assign scaled = {diff, 8'h00} - {8'h00, diff};

  // One restoring step: bring in the next numerator bit, try the subtract.
  assign trial    = {1'b0, rem, num_low[pmmcs_pkg::LEVEL_W-1]} - {2'b00, den};
  assign trial_ge = !trial[pmmcs_pkg::RAW_W+1];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= pmmcs_pkg::MODE_U8;
    end else if (cfg_wr_en) begin
      pixel_mode <= cfg_wr_data;
    end
  end

  // Sequencer, range tracking and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pmmcs_pkg::S_IDLE;
      range_low  <= pmmcs_pkg::RANGE_LOW_INIT;
      range_high <= pmmcs_pkg::RANGE_HIGH_INIT;
      step_cnt   <= '0;
    end else begin
      unique case (state)
        pmmcs_pkg::S_IDLE: begin
          if (in_xfer) begin
            priority if (opcode == pmmcs_pkg::OP_CLEAR) begin
              range_low  <= pmmcs_pkg::RANGE_LOW_INIT;
              range_high <= pmmcs_pkg::RANGE_HIGH_INIT;
            end else if (opcode == pmmcs_pkg::OP_MEASURE) begin
              if (stretching) begin
                if (in_offset < range_low) begin
                  range_low <= in_offset;
                end
                if (in_offset > range_high) begin
                  range_high <= in_offset;
                end
              end
            end else if (opcode == pmmcs_pkg::OP_CONVERT) begin
              vs <= in_offset;
              if (stretching) begin
                state <= pmmcs_pkg::S_PREP;
              end else begin
                quot  <= direct_level;
                state <= pmmcs_pkg::S_EMIT;
              end
            end else begin
              // unused opcode: drop
              state <= pmmcs_pkg::S_IDLE;
            end
          end
        end

        pmmcs_pkg::S_PREP: begin
          diff <= vs - range_low;
          den  <= range_high - range_low;
          priority if ((range_high <= range_low) || (vs <= range_low)) begin
            quot  <= '0;
            state <= pmmcs_pkg::S_EMIT;
          end else if (vs >= range_high) begin
            quot  <= pmmcs_pkg::LEVEL_MAX;
            state <= pmmcs_pkg::S_EMIT;
          end else begin
            state <= pmmcs_pkg::S_SCALE;
          end
        end

        pmmcs_pkg::S_SCALE: begin
          // quotient < 256, so the high part starts below the divisor
          rem      <= scaled[pmmcs_pkg::RAW_W+7:8];
          num_low  <= scaled[7:0];
          quot     <= '0;
          step_cnt <= '0;
          state    <= pmmcs_pkg::S_DIV;
        end

        pmmcs_pkg::S_DIV: begin
          if (trial_ge) begin
            rem <= trial[pmmcs_pkg::RAW_W-1:0];
          end else begin
            rem <= {rem[pmmcs_pkg::RAW_W-2:0], num_low[pmmcs_pkg::LEVEL_W-1]};
          end
          num_low  <= {num_low[pmmcs_pkg::LEVEL_W-2:0], 1'b0};
          quot     <= {quot[pmmcs_pkg::LEVEL_W-2:0], trial_ge};
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == pmmcs_pkg::STEP_W'(pmmcs_pkg::LEVEL_W - 1)) begin
            state <= pmmcs_pkg::S_EMIT;
          end
        end

        pmmcs_pkg::S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            state <= pmmcs_pkg::S_IDLE;
          end
        end

        default: begin
          state <= pmmcs_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == pmmcs_pkg::S_EMIT) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pmmcs_pkg::S_EMIT) && (!out_valid || !out_stall)) begin
      gray_level <= quot;
    end
  end

  // Assertions
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == pmmcs_pkg::S_DIV) |-> (den != '0))
    else $error("divider running with a zero divisor");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == pmmcs_pkg::S_DIV) |-> (rem < den))
    else $error("partial remainder not below divisor");

  a_convert_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (opcode == pmmcs_pkg::OP_CONVERT)) |=>
      ((state == pmmcs_pkg::S_PREP) || (state == pmmcs_pkg::S_EMIT)))
    else $error("convert transfer did not start a conversion");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    ((range_low == pmmcs_pkg::RANGE_LOW_INIT) && (range_high == pmmcs_pkg::RANGE_HIGH_INIT))
      || (range_low <= range_high))
    else $error("measured range out of order");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == pmmcs_pkg::S_EMIT))
    else $error("output loaded outside the emit step");

endmodule

[test/pixel_min_max_contrast_stretch_test.sv]
// Self-checking testbench for the min/max contrast stretch gray-level block.
module pixel_min_max_contrast_stretch_test;

  // Codes that the package enums do not name: the spare opcode and the spare modes,
  // which must still be exercised because the fields allow them.
  localparam logic [1:0] OP_SPARE         = 2'd3;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  localparam int RESET_CYCLES = 10;
  // Leave room after the worst convert for a late clear or measure.
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int BLOCK_ITEMS  = 38;
  localparam int CYCLE_LIMIT  = 500000;

  // Track the measured range and predict the gray level of every convert.
  class gray_level_scoreboard;
    localparam bit [31:0] LEVEL_TOP = 255;
    localparam bit [31:0] RAW_TOP   = 65535;
    localparam bit [31:0] RAW_MASK  = (32'd1 << pmmcs_pkg::SAMPLE_BITS) - 1;

    logic [2:0]                    mode;
    logic [pmmcs_pkg::RAW_W-1:0]   range_low;
    logic [pmmcs_pkg::RAW_W-1:0]   range_high;
    logic [pmmcs_pkg::LEVEL_W-1:0] levels_due[$];
    int                            errors;

    function new();
      mode       = pmmcs_pkg::MODE_U8;
      range_low  = pmmcs_pkg::RANGE_LOW_INIT;
      range_high = pmmcs_pkg::RANGE_HIGH_INIT;
      errors     = 0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    function bit stretching();
      return mode == pmmcs_pkg::MODE_S8 || mode == pmmcs_pkg::MODE_S16;
    endfunction

    // Shift a signed sample up so that its most negative value lands on zero.
    function logic [pmmcs_pkg::RAW_W-1:0] offset_sample(logic [pmmcs_pkg::RAW_W-1:0] raw);
      bit [31:0] u;
      if (mode == pmmcs_pkg::MODE_S8) begin
        return {8'h00, raw[7:0] ^ 8'h80};
      end
      u = raw & RAW_MASK;
      if (u[pmmcs_pkg::SAMPLE_BITS-1]) begin
        u = u + 32'h10000 - (32'd1 << pmmcs_pkg::SAMPLE_BITS);
      end
      return pmmcs_pkg::RAW_W'(u + 32'h8000);
    endfunction

    function logic [pmmcs_pkg::LEVEL_W-1:0] predict_level(logic [pmmcs_pkg::RAW_W-1:0] raw);
      bit [31:0] v;
      bit [31:0] lo;
      bit [31:0] hi;
      lo = range_low;
      hi = range_high;
      if (stretching()) begin
        v = offset_sample(raw);
        // Flat or empty range gives black; outside the range saturates.
        if (hi <= lo || v <= lo) begin
          return '0;
        end
        if (v >= hi) begin
          return pmmcs_pkg::LEVEL_MAX;
        end
        return pmmcs_pkg::LEVEL_W'(((v - lo) * LEVEL_TOP) / (hi - lo));
      end
      if (mode == pmmcs_pkg::MODE_U16) begin
        return pmmcs_pkg::LEVEL_W'(((raw & RAW_MASK) * LEVEL_TOP) / RAW_TOP);
      end
      // Color, unsigned8 and the spare modes pass the low byte.
      return raw[7:0];
    endfunction

    function void note_sample(logic [1:0] op, logic [pmmcs_pkg::RAW_W-1:0] raw);
      logic [pmmcs_pkg::RAW_W-1:0] v;
      if (op == pmmcs_pkg::OP_CLEAR) begin
        range_low  = pmmcs_pkg::RANGE_LOW_INIT;
        range_high = pmmcs_pkg::RANGE_HIGH_INIT;
      end else if (op == pmmcs_pkg::OP_MEASURE) begin
        if (stretching()) begin
          v = offset_sample(raw);
          if (v < range_low) range_low = v;
          if (v > range_high) range_high = v;
        end
      end else if (op == pmmcs_pkg::OP_CONVERT) begin
        levels_due.push_back(predict_level(raw));
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_level(logic [pmmcs_pkg::LEVEL_W-1:0] level);
      logic [pmmcs_pkg::LEVEL_W-1:0] want;
      if (levels_due.size() == 0) begin
        report($sformatf("gray_level %0d with no convert pending", level));
      end else begin
        want = levels_due.pop_front();
        if (level !== want) begin
          report($sformatf("gray_level %0d, predicted %0d", level, want));
        end
      end
    endtask
  endclass

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          cfg_wr_en   = 1'b0;
  logic [2:0]                    cfg_wr_data = pmmcs_pkg::MODE_U8;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [1:0]                    opcode      = pmmcs_pkg::OP_CLEAR;
  logic [pmmcs_pkg::RAW_W-1:0]   sample      = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic [pmmcs_pkg::LEVEL_W-1:0] gray_level;

  gray_level_scoreboard sb = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  pixel_min_max_contrast_stretch DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gray_level (gray_level)
  );

  always #1 clk = ~clk;

  // Count cycles; the watcher below ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when the stimulus asks for one.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Check every level that completes a transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_level(gray_level);
    end
  end

  // Offer one item, with random idle cycles ahead of it; return at the edge
  // where the transfer happens. Call only at a rising edge.
  task send_item(logic [1:0] op, logic [pmmcs_pkg::RAW_W-1:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(op, smp);
  endtask

  // Drop valid, wait for every pending level, then let the block go quiet.
  task drain();
    in_valid <= 1'b0;
    while (sb.levels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_mode(logic [2:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(m);
  endtask

  task set_idling(int in_pct, int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct <= out_pct;
  endtask

  // Mostly full-range values, with weight on the extremes and the signed edges.
  function logic [pmmcs_pkg::RAW_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 16'h8000 | pmmcs_pkg::RAW_W'($urandom_range(0, 3));
      3: return {8'($urandom_range(0, 255)), ($urandom_range(1) ? 8'h80 : 8'h7F)};
      default: return pmmcs_pkg::RAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Send about quota items that the block acts on. In the stretch modes most
  // items form frames: clear, measure pass, convert pass; the rest are strays
  // and frames with no clear ahead of them.
  task run_block(logic [2:0] m, int quota);
    int                          done;
    int                          n_meas;
    int                          n_conv;
    logic [1:0]                  op;
    logic [pmmcs_pkg::RAW_W-1:0] s;
    logic [pmmcs_pkg::RAW_W-1:0] measured[$];
    done = 0;
    while (done < quota) begin
      if (m == pmmcs_pkg::MODE_S8 || m == pmmcs_pkg::MODE_S16) begin
        if ($urandom_range(9) == 0) begin
          op = 2'($urandom_range(pmmcs_pkg::OP_CLEAR, OP_SPARE));
          send_item(op, rand_sample());
          if (op != OP_SPARE) done++;
        end else begin
          measured.delete();
          if ($urandom_range(7) != 0) begin
            send_item(pmmcs_pkg::OP_CLEAR, rand_sample());
            done++;
          end
          n_meas = $urandom_range(1, 8);
          repeat (n_meas) begin
            s = rand_sample();
            measured.push_back(s);
            send_item(pmmcs_pkg::OP_MEASURE, s);
            done++;
          end
          n_conv = $urandom_range(1, 10);
          repeat (n_conv) begin
            // Reuse measured values now and then to land on the range ends.
            if ($urandom_range(3) == 0) begin
              s = measured[$urandom_range(0, measured.size() - 1)];
            end else begin
              s = rand_sample();
            end
            send_item(pmmcs_pkg::OP_CONVERT, s);
            done++;
          end
        end
      end else begin
        case ($urandom_range(19))
          0: begin
            send_item(pmmcs_pkg::OP_CLEAR, rand_sample());
            done++;
          end
          1: send_item(pmmcs_pkg::OP_MEASURE, rand_sample());
          2: send_item(OP_SPARE, rand_sample());
          default: begin
            send_item(pmmcs_pkg::OP_CONVERT, rand_sample());
            done++;
          end
        endcase
      end
    end
  endtask

  int         in_pcts[4]  = '{0, 73, 0, 36};
  int         out_pcts[4] = '{0, 0, 73, 36};
  logic [2:0] mode_seq[8] = '{pmmcs_pkg::MODE_S16, pmmcs_pkg::MODE_S8, pmmcs_pkg::MODE_U16,
                              pmmcs_pkg::MODE_COLOR, pmmcs_pkg::MODE_U8, MODE_SPARE_FIRST,
                              pmmcs_pkg::MODE_S8, pmmcs_pkg::MODE_S16};

  initial begin
    logic [2:0] m;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: mode after reset is unsigned8 pass.
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'hFFFF);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h12A5);
    send_item(OP_SPARE, 16'hFFFF);
    send_item(pmmcs_pkg::OP_MEASURE, 16'h0000);
    write_mode(pmmcs_pkg::MODE_COLOR);
    send_item(pmmcs_pkg::OP_CONVERT, 16'hAB55);
    // Unsigned16 scale: ends, and the low byte just at and below the high byte.
    write_mode(pmmcs_pkg::MODE_U16);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'hFFFF);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0101);
    send_item(pmmcs_pkg::OP_CONVERT, 16'hFF00);
    // Signed8: empty range first, then the full signed span.
    write_mode(pmmcs_pkg::MODE_S8);
    send_item(pmmcs_pkg::OP_CLEAR, 16'h0000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0080);
    send_item(pmmcs_pkg::OP_MEASURE, 16'h0080);
    send_item(pmmcs_pkg::OP_MEASURE, 16'hFF7F);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h007F);
    // Signed16: empty, flat, then full span with both ends and the middle.
    write_mode(pmmcs_pkg::MODE_S16);
    send_item(pmmcs_pkg::OP_CLEAR, 16'hFFFF);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0005);
    send_item(pmmcs_pkg::OP_MEASURE, 16'h0005);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0005);
    send_item(pmmcs_pkg::OP_MEASURE, 16'h8000);
    send_item(pmmcs_pkg::OP_MEASURE, 16'h7FFF);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h0000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h8000);
    send_item(pmmcs_pkg::OP_CONVERT, 16'h7FFF);
    // Spare mode falls back to the unsigned8 pass.
    write_mode(MODE_SPARE_LAST);
    send_item(pmmcs_pkg::OP_CONVERT, 16'hBEEF);

    // Random: each idling profile walks through every named mode and one random spare mode.
    for (int p = 0; p < 4; p++) begin
      drain();
      set_idling(in_pcts[p], out_pcts[p]);
      for (int i = 0; i < 8; i++) begin
        m = mode_seq[i];
        if (m == MODE_SPARE_FIRST) begin
          m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        write_mode(m);
        run_block(m, BLOCK_ITEMS);
      end
    end

    // Pressure: hold the output off while converts keep coming, so the
    // output register and the divider fill up and the input stalls.
    drain();
    set_idling(0, 0);
    write_mode(pmmcs_pkg::MODE_S16);
    send_item(pmmcs_pkg::OP_CLEAR, 16'h0000);
    repeat (4) send_item(pmmcs_pkg::OP_MEASURE, rand_sample());
    hold_req <= hold_req + 1;
    repeat (40) send_item(pmmcs_pkg::OP_CONVERT, rand_sample());

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
